// File: src/lcc_pkg.sv
// lcc_pkg: shared types, constants and the key folding function
// for the lru cache hit cost counter; no dependencies
`default_nettype none

package lcc_pkg;

    localparam int KEY_W   = 64;
    localparam int COST_W  = 3;
    localparam int TOTAL_W = 32;
    localparam int CAP_W   = 6;

    localparam logic [COST_W-1:0] HIT_COST  = 3'd1;
    localparam logic [COST_W-1:0] MISS_COST = 3'd5;

    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic hit;
    } cell_ctrl_t;

    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       c;
        r = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            c = k[b*8 +: 8];
            if (c >= 8'h41 && c <= 8'h5A) begin
                c = c + 8'h20;
            end
            r[b*8 +: 8] = c;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/lcc_cell.sv
// lcc_cell: one rank of the recency chain, holds a key and its valid bit
// depends on lcc_pkg
`default_nettype none

module lcc_cell
    import lcc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int OCC_W = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [KEY_W-1:0] new_key,
    input  wire logic [KEY_W-1:0] key_in,
    input  wire logic             found_in,
    input  wire logic [OCC_W-1:0] occ_cur,
    input  wire logic [OCC_W-1:0] occ_next,
    output logic      [KEY_W-1:0] key_out,
    output logic                  found_out
);

    localparam logic [OCC_W-1:0] MY_RANK = OCC_W'(IDX);

    logic [KEY_W-1:0] key_reg;
    logic             valid_reg;
    logic             match_reg;
    logic             shift;

    // on a hit, ranks up to the match take the neighbor's key; on a miss, ranks up to occupancy
    assign shift     = ctrl.hit ? !found_in : (MY_RANK <= occ_cur);
    assign found_out = found_in | match_reg;
    assign key_out   = key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctrl.cmp_en) begin
                match_reg <= valid_reg && (key_reg == new_key);
            end
            if (ctrl.upd_en) begin
                valid_reg <= (MY_RANK < occ_next);
                match_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.upd_en && shift) begin
            key_reg <= key_in;
        end
    end

endmodule

`default_nettype wire

// File: src/lru_cache_hit_cost_counter_core.sv
// lru_cache_hit_cost_counter_core: top level, control sequencer, occupancy,
// running total and output register; depends on lcc_pkg and lcc_cell
`default_nettype none

// Fully associative lru cache of up to CAPACITY folded keys, kept in a chain
// of cells ordered by recency (cell 0 is most recent). Each item's key is
// folded and registered, then every cell compares against it, then the
// match ripples along the cell chain as the cells shift toward the oldest
// rank. The result sits in an output register, so the next item is taken
// while a result waits; the block then stalls in its last step only if the
// result register is still full. Capacity is written on the cfg channel;
// the user writes it only while idle, which the block does not enforce.
// Values above CAPACITY act as CAPACITY and zero makes every access a miss.
// m_tdata: bit 0 hit, bits 3:1 cost, bits 35:4 total_cost, rest zero.

module lru_cache_hit_cost_counter_core
    import lcc_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int KEY_BYTES = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // cfg: capacity
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data,
    // s_tdata: key[63:0]
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [63:0]      s_tdata,
    // m_tdata: hit[0], cost[3:1], total_cost[35:4], zero[39:36]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [39:0]      m_tdata
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);
    localparam logic [CW-1:0]    CAP_MAX  = CW'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [KEY_W-1:0]   key_reg;
    logic               m_valid_reg;
    logic               hit_out_reg;
    logic [COST_W-1:0]  cost_out_reg;
    logic [TOTAL_W-1:0] total_out_reg;

    logic               s_fire;
    logic               upd_go;
    logic               hit;
    logic [COST_W-1:0]  cost;
    logic [CW-1:0]      cap_eff;
    logic [CW-1:0]      occ_ext;
    logic [CW-1:0]      occ_inc;
    logic [TOTAL_W:0]   total_sum;
    cell_ctrl_t         ctrl;

    logic [KEY_W-1:0]   chain_key [CAPACITY];
    logic [CAPACITY:0]  found;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign upd_go    = (state_reg == ST_UPD) && (!m_valid_reg || m_tready);

    assign cap_eff = (CW'(cap_reg) > CAP_MAX) ? CAP_MAX : CW'(cap_reg);
    assign hit     = found[CAPACITY] && (cap_eff != '0);
    assign cost    = hit ? HIT_COST : MISS_COST;

    assign occ_ext = CW'(occ_reg);
    always_comb begin
        occ_inc = (occ_ext < CAP_MAX) ? occ_ext + CW'(1) : occ_ext;
        if (hit) begin
            occ_next = occ_reg;
        end else if (occ_inc > cap_eff) begin
            occ_next = cap_eff[OCC_W-1:0];
        end else begin
            occ_next = occ_inc[OCC_W-1:0];
        end
    end

    assign total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(cost);
    assign total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

    assign ctrl.cmp_en = (state_reg == ST_CMP);
    assign ctrl.upd_en = upd_go;
    assign ctrl.hit    = hit;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (upd_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        lcc_cell #(
            .IDX   (i),
            .OCC_W (OCC_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .new_key   (key_reg),
            .key_in    ((i == 0) ? key_reg : chain_key[(i == 0) ? 0 : i - 1]),
            .found_in  (found[i]),
            .occ_cur   (occ_reg),
            .occ_next  (occ_next),
            .key_out   (chain_key[i]),
            .found_out (found[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_W'(32);
            occ_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (upd_go) begin
                occ_reg     <= occ_next;
                total_reg   <= total_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            key_reg <= fold_key(s_tdata & KEY_MASK);
        end
        if (upd_go) begin
            hit_out_reg   <= hit;
            cost_out_reg  <= cost;
            total_out_reg <= total_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, total_out_reg, cost_out_reg, hit_out_reg};

endmodule

`default_nettype wire

// File: src/lcc_checker.sv
// lcc_checker: port level assertions for lru_cache_hit_cost_counter_core
// and the bind that attaches them; depends on the top level only
`default_nettype none

module lcc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // a stalled result holds its item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_cost_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] == 3'd1) || (m_tdata[3:1] == 3'd5))
        else $error("cost is neither hit nor miss cost");

    a_hit_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == 3'd1)))
        else $error("hit flag and cost disagree");

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:36] == 4'd0))
        else $error("padding bits not zero");

endmodule

bind lru_cache_hit_cost_counter_core lcc_checker u_lcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
